### rtl/adsr_pkg.sv
// Shared types, constants and helper functions for the ADSR voice envelope.
package adsr_pkg;

  localparam int CNT_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int LVL_W    = FRAC_W + 1;
  localparam int LEN_W    = 24;
  localparam int NUM_W    = LEN_W + LVL_W;
  localparam int CNT_IX_W = 5;

  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Input operation codes.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ON   = 2'd1;
  localparam logic [1:0] OP_OFF  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;
  localparam logic [1:0] REG_SUSTAIN = 2'd3;

  // Which envelope segment a running division belongs to.
  localparam logic [1:0] SEG_ATTACK  = 2'd0;
  localparam logic [1:0] SEG_DECAY   = 2'd1;
  localparam logic [1:0] SEG_RELEASE = 2'd2;

  // One queued event: the op and either the mix or the clamped velocity.
  typedef struct packed {
    logic [1:0]       op;
    logic [LVL_W-1:0] data;
  } q_entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Signed divide by three, truncated toward zero.
  function automatic logic signed [15:0] div3(input logic signed [15:0] x);
    logic [15:0] mag;
    logic [32:0] prod;
    logic [15:0] q;
    begin
      mag  = x[15] ? 16'(-x) : 16'(x);
      prod = {17'd0, mag} * 33'd43691;
      q    = prod[32:17];
      div3 = x[15] ? -$signed(q) : $signed(q);
    end
  endfunction

  // Clamp a Q1.16 level to unity.
  function automatic logic [LVL_W-1:0] clamp_one(input logic [LVL_W-1:0] v);
    clamp_one = (v > LVL_ONE) ? LVL_ONE : v;
  endfunction

endpackage

### rtl/adsr_voice_envelope.sv
// Top level of the linear ADSR envelope for one synth voice.
// Usage:
//   The in_ channel carries events: in_op selects a sample tick, note on or
//   note off; ticks bring three oscillator samples, note on a velocity gain.
//   Each tick yields one out_ transaction with the enveloped sample and the
//   voice activity flag; note events and the unused op yield nothing.
//   The cfg_ channel writes attack, decay, release lengths and sustain level
//   (index 0 to 3) and is always ready. The user writes it while the block
//   idles; the block itself does not enforce this.
// Timing:
//   Input transactions go into a two-entry queue and are taken while it has
//   room. The back part handles a note event in its idle state. A tick
//   passes through the plan and output states; in attack, decay or release
//   the 17-step serial divider between them computes the level.
// Stalls and reset:
//   Results sit in an output register until taken; a stalled receiver holds
//   the back part, then the queue fills and in_ready drops. Synchronous
//   active-low reset clears the voice, the queue and the registers (sustain
//   to unity).
module adsr_voice_envelope (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_osc_a,
  input  logic signed [15:0] in_osc_b,
  input  logic signed [15:0] in_osc_c,
  input  logic [16:0]        in_velocity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  output logic               out_voice_active,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import adsr_pkg::*;

  q_stat_t  stat;
  q_entry_t push_data, pop_data;
  logic     push, pop;

  // Event classification and mixing.
  adsr_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_osc_a    (in_osc_a),
    .in_osc_b    (in_osc_b),
    .in_osc_c    (in_osc_c),
    .in_velocity (in_velocity),
    .stat        (stat),
    .push        (push),
    .push_data   (push_data)
  );

  // Event queue.
  adsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  // Envelope engine.
  adsr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .stat             (stat),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_voice_active (out_voice_active)
  );
endmodule

### rtl/adsr_queue.sv
// Two-entry queue between the front and back parts.
module adsr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  adsr_pkg::q_entry_t push_data,
  input  logic              pop,
  output adsr_pkg::q_entry_t pop_data,
  output adsr_pkg::q_stat_t  stat
);
  import adsr_pkg::*;

  q_entry_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign pop_data   = mem_r[rptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule

### rtl/adsr_front.sv
// Front part: accepts input transactions, mixes oscillators, queues events.
module adsr_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_osc_a,
  input  logic signed [15:0] in_osc_b,
  input  logic signed [15:0] in_osc_c,
  input  logic [16:0]        in_velocity,
  input  adsr_pkg::q_stat_t  stat,
  output logic               push,
  output adsr_pkg::q_entry_t push_data
);
  import adsr_pkg::*;

  logic signed [LVL_W-1:0] mix;
  logic                    known_op;

  // Mix of the three samples, each divided by three first.
  assign mix = LVL_W'(div3(in_osc_a)) + LVL_W'(div3(in_osc_b)) + LVL_W'(div3(in_osc_c));

  assign known_op = (in_op == OP_TICK) || (in_op == OP_ON) || (in_op == OP_OFF);
  assign in_ready = !stat.full;
  // An unused op is taken and dropped.
  assign push     = in_valid && in_ready && known_op;

  // Payload: the mix for a tick, the clamped velocity for a note on.
  always_comb begin
    push_data.op = in_op;
    if (in_op == OP_ON) begin
      push_data.data = clamp_one(in_velocity);
    end else begin
      push_data.data = mix;
    end
  end
endmodule

### rtl/adsr_back.sv
// Back part: envelope state, serial divider and output register.
module adsr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  adsr_pkg::q_stat_t  stat,
  input  adsr_pkg::q_entry_t pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  output logic               out_voice_active
);
  import adsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PLAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r;

  logic [LEN_W-1:0]  attack_r, decay_r, release_r;
  logic [LVL_W-1:0]  sustain_r;
  logic [CNT_W-1:0]  count_r, rel_start_r;
  logic              gate_r, active_r;
  logic [LVL_W-1:0]  env_r, vgain_r;
  logic signed [LVL_W-1:0] mix_r;
  logic [15:0]       smag_r;
  logic              sneg_r;
  logic [LVL_W-1:0]  num_r;
  logic [LEN_W-1:0]  rem_r, den_r;
  logic [LVL_W-1:0]  quo_r;
  logic [CNT_IX_W-1:0] dcnt_r;
  logic [1:0]        seg_r;
  logic signed [15:0] out_sample_r;
  logic              out_active_r, out_valid_r;

  logic [LVL_W-1:0]  sus;
  logic [CNT_W-1:0]  elapsed;
  logic [LEN_W:0]    ad_sum;
  logic [15:0]       mix_mag;
  logic [32:0]       sprod;
  logic [LEN_W-1:0]  mul_a;
  logic [LVL_W-1:0]  mul_b;
  logic [NUM_W-1:0]  nprod;
  logic [LEN_W:0]    trial;
  logic              ge;
  logic [LVL_W-1:0]  q_fin;
  logic [32:0]       oprod;
  logic [15:0]       omag;
  logic              out_load;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_voice_active = out_active_r;

  assign sus     = clamp_one(sustain_r);
  assign elapsed = (count_r >= rel_start_r) ? count_r - rel_start_r : '0;
  assign ad_sum  = {1'b0, attack_r} + {1'b0, decay_r};
  assign mix_mag = mix_r[LVL_W-1] ? 16'(-mix_r) : 16'(mix_r);
  assign sprod   = {17'd0, mix_mag} * {16'd0, vgain_r};

  // Operand selection for the numerator product of the division.
  always_comb begin
    if (!gate_r) begin
      mul_a = elapsed[LEN_W-1:0];
      mul_b = sus;
    end else if (count_r < CNT_W'(attack_r)) begin
      mul_a = count_r[LEN_W-1:0];
      mul_b = LVL_ONE;
    end else begin
      mul_a = LEN_W'(count_r - CNT_W'(attack_r));
      mul_b = LVL_ONE - sus;
    end
  end
  assign nprod = {{LVL_W{1'b0}}, mul_a} * {{LEN_W{1'b0}}, mul_b};

  // One restoring divider step.
  assign trial = {rem_r, num_r[LVL_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign q_fin = {quo_r[LVL_W-2:0], ge};

  // Final gain by the envelope level.
  assign oprod    = {17'd0, smag_r} * {16'd0, env_r};
  assign omag     = oprod[31:16];
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign pop      = (state_r == S_IDLE) && !stat.empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      release_r <= '0;
      sustain_r <= LVL_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_data;
        REG_DECAY:   decay_r   <= cfg_data;
        REG_RELEASE: release_r <= cfg_data;
        REG_SUSTAIN: sustain_r <= cfg_data[LVL_W-1:0];
        default:     ;
      endcase
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (pop && pop_data.op == OP_TICK) mix_r <= pop_data.data;
    if (state_r == S_PLAN) begin
      smag_r <= sprod[31:16];
      sneg_r <= mix_r[LVL_W-1];
      rem_r  <= nprod[NUM_W-1:LVL_W];
      num_r  <= nprod[LVL_W-1:0];
      dcnt_r <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r  <= ge ? LEN_W'(trial - {1'b0, den_r}) : trial[LEN_W-1:0];
      num_r  <= num_r << 1;
      quo_r  <= q_fin;
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (out_load) begin
      out_sample_r <= sneg_r ? -$signed(omag) : $signed(omag);
      out_active_r <= active_r;
    end
  end

  // Sequencer and voice state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rel_start_r <= '0;
      gate_r      <= 1'b0;
      active_r    <= 1'b0;
      env_r       <= '0;
      vgain_r     <= '0;
      out_valid_r <= 1'b0;
      seg_r       <= SEG_ATTACK;
      den_r       <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            case (pop_data.op)
              OP_ON: begin
                count_r     <= '0;
                rel_start_r <= '0;
                env_r       <= '0;
                vgain_r     <= pop_data.data;
                gate_r      <= 1'b1;
                active_r    <= 1'b1;
              end
              OP_OFF: begin
                gate_r      <= 1'b0;
                rel_start_r <= count_r;
              end
              default: begin
                if (count_r != CNT_MAX) count_r <= count_r + 1'b1;
                state_r <= S_PLAN;
              end
            endcase
          end
        end
        S_PLAN: begin
          state_r <= S_OUT;
          if (active_r) begin
            if (!gate_r) begin
              if (release_r == '0 || elapsed >= CNT_W'(release_r)) begin
                env_r    <= '0;
                active_r <= 1'b0;
              end else begin
                seg_r   <= SEG_RELEASE;
                den_r   <= release_r;
                state_r <= S_DIV;
              end
            end else if (count_r < CNT_W'(attack_r)) begin
              seg_r   <= SEG_ATTACK;
              den_r   <= attack_r;
              state_r <= S_DIV;
            end else if (count_r < CNT_W'(ad_sum)) begin
              seg_r   <= SEG_DECAY;
              den_r   <= decay_r;
              state_r <= S_DIV;
            end else begin
              env_r <= sus;
            end
          end
        end
        S_DIV: begin
          if (dcnt_r == CNT_IX_W'(LVL_W - 1)) begin
            state_r <= S_OUT;
            case (seg_r)
              SEG_ATTACK: env_r <= q_fin;
              SEG_DECAY:  env_r <= LVL_ONE - q_fin;
              default: begin
                if (q_fin >= sus) begin
                  env_r    <= '0;
                  active_r <= 1'b0;
                end else begin
                  env_r <= sus - q_fin;
                end
              end
            endcase
          end
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### test/tb_adsr_voice_envelope.sv
// Self-checking testbench for the ADSR voice envelope: random events, stalls and register phases.
module tb_adsr_voice_envelope;
  import adsr_pkg::*;

  // Envelope predictor and the queue of predicted samples.
  class envelope_scoreboard;
    longint unsigned attack_len, decay_len, release_len, sustain_raw;
    longint unsigned count, rel_start, level, gain;
    bit gate, active;
    logic [15:0] pending_sample[$];
    bit pending_active[$];
    int errors;

    function void clear();
      attack_len = 0; decay_len = 0; release_len = 0; sustain_raw = 65536;
      count = 0; rel_start = 0; level = 0; gain = 0; gate = 0; active = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        REG_ATTACK:  attack_len = data;
        REG_DECAY:   decay_len = data;
        REG_RELEASE: release_len = data;
        REG_SUSTAIN: sustain_raw = data[16:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sat_one(longint unsigned v);
      return (v > 65536) ? 65536 : v;
    endfunction

    function longint apply_gain(longint v, longint unsigned g);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag * g) >> 16;
      return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Note an accepted input transaction and predict its result, if any.
    function void note_input(logic [1:0] op, logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, logic [16:0] vel);
      longint mix, scaled, res;
      longint unsigned s, el, drop;
      if (op == OP_ON) begin
        count = 0; rel_start = 0; level = 0; gain = sat_one(vel);
        gate = 1; active = 1;
      end else if (op == OP_OFF) begin
        gate = 0; rel_start = count;
      end else if (op == OP_TICK) begin
        mix = longint'(a) / 3 + longint'(b) / 3 + longint'(c) / 3;
        scaled = apply_gain(mix, gain);
        if (count < 64'hFFFF_FFFF) count++;
        if (active) begin
          s = sat_one(sustain_raw);
          if (count < attack_len) level = (count * 65536) / attack_len;
          else if (count < attack_len + decay_len)
            level = 65536 - ((count - attack_len) * (65536 - s)) / decay_len;
          else if (gate) level = s;
          if (!gate) begin
            el = (count >= rel_start) ? count - rel_start : 0;
            if (release_len == 0 || el >= release_len) begin
              level = 0; active = 0;
            end else begin
              drop = (s * el) / release_len;
              if (drop >= s) begin
                level = 0; active = 0;
              end else begin
                level = s - drop;
              end
            end
          end
        end
        res = apply_gain(scaled, level);
        pending_sample.push_back(res[15:0]);
        pending_active.push_back(active);
      end
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(logic [15:0] smp, logic act);
      logic [15:0] es;
      bit ea;
      if (pending_sample.size() == 0) begin
        $error("unexpected result sample_out=%0d", $signed(smp));
        errors++;
        return;
      end
      es = pending_sample.pop_front();
      ea = pending_active.pop_front();
      if (es !== smp) begin
        $error("sample_out expected %0d actual %0d", $signed(es), $signed(smp));
        errors++;
      end
      if (ea !== act) begin
        $error("voice_active expected %0d actual %0d", ea, act);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_op = OP_TICK;
  logic signed [15:0] in_osc_a = 0, in_osc_b = 0, in_osc_c = 0;
  logic [16:0] in_velocity = 0;
  logic out_valid, out_ready = 0;
  logic signed [15:0] out_sample_out;
  logic out_voice_active;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = REG_ATTACK;
  logic [23:0] cfg_data = 0;

  envelope_scoreboard envelope_sb;
  longint cycle_count = 0;
  bit hold_off = 0;
  bit driving_done = 0;

  adsr_voice_envelope uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when asked.
  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        envelope_sb.check_result(out_sample_out, out_voice_active);
      if (out_valid && out_ready) begin
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (hold_off) out_ready <= 0;
      else if (gap > 0) begin
        out_ready <= 0; gap--;
      end else out_ready <= 1;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [23:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    envelope_sb.write_reg(idx, data);
  endtask

  task automatic send_event(logic [1:0] op, logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c, logic [16:0] vel);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_op <= op; in_osc_a <= a; in_osc_b <= b; in_osc_c <= c;
    in_velocity <= vel;
    do @(posedge clk); while (!in_ready);
    envelope_sb.note_input(op, a, b, c, vel);
  endtask

  task automatic send_random_tick();
    send_event(OP_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Wait until all results are in, then for the block's latency.
  task automatic drain();
    in_valid <= 0;
    while (envelope_sb.pending_sample.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_envelope(logic [23:0] a, logic [23:0] d, logic [23:0] r,
                              logic [23:0] s);
    write_cfg(REG_ATTACK, a);
    write_cfg(REG_DECAY, d);
    write_cfg(REG_RELEASE, r);
    write_cfg(REG_SUSTAIN, s);
    cfg_valid <= 0;
  endtask

  initial begin : driver
    int n, i;
    envelope_sb = new();
    envelope_sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: default registers, extremes of samples and velocity.
    send_random_tick();
    send_event(OP_ON, 0, 0, 0, 17'h1FFFF);
    send_event(OP_TICK, 32767, 32767, 32767, 0);
    send_event(OP_TICK, -32768, -32768, -32768, 0);
    send_event(OP_TICK, -1, 1, -2, 0);
    send_event(2'd3, 5, 5, 5, 5);
    send_event(OP_OFF, 0, 0, 0, 0);
    send_event(OP_TICK, 32767, -32768, 100, 0);
    send_event(OP_TICK, 1000, 1000, 1000, 0);
    drain();
    // Short envelope with sustain above unity, walk through attack, decay and release.
    set_envelope(3, 4, 5, 24'h1FFFF);
    send_event(OP_ON, 0, 0, 0, 65536);
    repeat (4) send_event(OP_TICK, 32767, 32767, 32767, 0);
    send_event(OP_OFF, 0, 0, 0, 0);
    repeat (7) send_event(OP_TICK, -32768, -32768, -32768, 0);
    drain();
    set_envelope(5, 6, 3, 30000);
    send_event(OP_ON, 0, 0, 0, 40000);
    send_event(OP_TICK, 9000, -9000, 20000, 0);
    send_event(OP_OFF, 0, 0, 0, 0);
    repeat (4) send_event(OP_TICK, 9000, 9000, 9000, 0);
    drain();

    // Random phases with varied register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_envelope(0, 0, 0, 0);
        1: set_envelope(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 65536);
        2: set_envelope(1, 1, 1, 1);
        default: set_envelope($urandom_range(0, 40), $urandom_range(0, 40),
                              $urandom_range(0, 40), $urandom_range(0, 24'h1FFFF));
      endcase
      if (ph == 3) hold_off = 1;
      for (n = 0; n < 125; ) begin
        // Mostly a well-formed note: on, ticks, off, ticks.
        if ($urandom_range(0, 9) < 8) begin
          send_event(OP_ON, $urandom, $urandom, $urandom, $urandom);
          n++;
          for (i = $urandom_range(0, 50); i > 0; i--) begin
            send_random_tick(); n++;
          end
          send_event(OP_OFF, $urandom, $urandom, $urandom, $urandom);
          n++;
          for (i = $urandom_range(0, 50); i > 0; i--) begin
            send_random_tick(); n++;
          end
        end else begin
          send_event($urandom, $urandom, $urandom, $urandom, $urandom);
          n++;
        end
      end
      hold_off = 0;
      drain();
    end

    if (envelope_sb.errors == 0 && envelope_sb.pending_sample.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Release the long hold-off after a counted stretch of cycles.
  initial begin : hold_timer
    forever begin
      @(posedge clk);
      if (hold_off) begin
        repeat (200) @(posedge clk);
        hold_off = 0;
        wait (0);
      end
    end
  end

endmodule
